FILE: design/tlve_pkg.sv
// Package for the TLV element encoder: transaction structs, action, status and kind codes,
// and the byte-length helpers used by the front part. No dependencies.
`timescale 1ns / 1ps
package tlve_pkg;

  localparam logic [1:0] ACT_WRITE    = 2'd0;
  localparam logic [1:0] ACT_FINALIZE = 2'd1;
  localparam logic [1:0] ACT_RESTART  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO_ID = 2'd1;
  localparam logic [1:0] ST_FINAL   = 2'd2;
  localparam logic [1:0] ST_KIND    = 2'd3;

  localparam logic [3:0] KIND_S32     = 4'd0;
  localparam logic [3:0] KIND_U32     = 4'd1;
  localparam logic [3:0] KIND_S64     = 4'd2;
  localparam logic [3:0] KIND_U64     = 4'd3;
  localparam logic [3:0] KIND_FLOAT   = 4'd4;
  localparam logic [3:0] KIND_DOUBLE  = 4'd5;
  localparam logic [3:0] KIND_BOOL    = 4'd6;
  localparam logic [3:0] KIND_VERSION = 4'd9;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  kind_code;
    logic [31:0] item_id;
    logic [63:0] value_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  // One classified element as it waits between front and back.
  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] id_al;   // id bytes left-aligned, most significant first
    logic [1:0]  idn;     // id byte count minus one
    logic [63:0] pay_al;  // payload bytes left-aligned
    logic [3:0]  plen;    // payload byte count, 0 to 8
    logic [1:0]  status;
    logic        single;  // one result without a stream byte
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_head_t;

  // Fewest bytes that hold v as an unsigned number; zero takes none.
  function automatic logic [3:0] ulen(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      if ((v >> (8 * k)) == 64'd0) n = 4'(k);
    end
    if (v == 64'd0) n = 4'd0;
    return n;
  endfunction

  // Fewest bytes that hold v as a two's complement number; zero takes none.
  function automatic logic [3:0] slen(input logic [63:0] v);
    logic [3:0]  n;
    logic [63:0] top;
    logic [63:0] mask;
    n = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      top  = v >> (8 * k - 1);
      mask = {64{1'b1}} >> (8 * k - 1);
      if (top == 64'd0 || top == mask) n = 4'(k);
    end
    if (v == 64'd0) n = 4'd0;
    return n;
  endfunction

endpackage

FILE: design/tlve_front.sv
// Front part of the TLV element encoder: checks each incoming element, keeps the
// finalized flag and turns the element into a descriptor. Depends on tlve_pkg.
`timescale 1ns / 1ps
module tlve_front import tlve_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output desc_t    desc
);

  logic        finalized_r;
  logic        finalized_nxt;
  logic [63:0] lo;
  logic [63:0] p;
  logic [3:0]  len;
  logic [3:0]  kind;
  logic [31:0] id;
  logic [1:0]  idn;
  logic        supported;
  logic [6:0]  pay_sh;
  logic [5:0]  id_sh;

  assign lo = {32'd0, item.value_bits[31:0]};
  assign supported = (item.kind_code <= KIND_BOOL) || (item.kind_code == KIND_VERSION);

  always_comb begin
    kind = item.kind_code;
    id   = item.item_id;
    p    = lo;
    len  = ulen(lo);
    unique case (item.kind_code)
      KIND_S32: begin
        p   = {{32{lo[31]}}, lo[31:0]};
        len = slen({{32{lo[31]}}, lo[31:0]});
      end
      KIND_U32: begin
        p   = lo;
        len = ulen(lo);
      end
      KIND_S64: begin
        p   = item.value_bits;
        len = slen(item.value_bits);
      end
      KIND_U64: begin
        p   = item.value_bits;
        len = ulen(item.value_bits);
      end
      KIND_FLOAT: begin
        p   = lo;
        len = 4'd4;
      end
      KIND_DOUBLE: begin
        p   = item.value_bits;
        len = 4'd8;
      end
      KIND_BOOL: begin
        p   = {63'd0, item.value_bits != 64'd0};
        len = 4'd1;
      end
      default: begin
        id = 32'd0;
      end
    endcase
    // A restart always emits a version element.
    if (item.action == ACT_RESTART) begin
      kind = KIND_VERSION;
      id   = 32'd0;
      p    = lo;
      len  = ulen(lo);
    end
  end

  always_comb begin
    if (id < 32'h100) idn = 2'd0;
    else if (id < 32'h1_0000) idn = 2'd1;
    else if (id < 32'h100_0000) idn = 2'd2;
    else idn = 2'd3;
  end

  assign id_sh  = {2'd3 - idn, 3'b000} + 6'd0;
  assign pay_sh = 7'd64 - {len, 3'b000};

  always_comb begin
    finalized_nxt = finalized_r;
    desc.tag    = {kind, idn, 2'b00};
    desc.id_al  = id << id_sh;
    desc.idn    = idn;
    desc.pay_al = p << pay_sh;
    desc.plen   = len;
    desc.status = ST_OK;
    desc.single = 1'b0;
    unique case (item.action)
      ACT_FINALIZE: begin
        finalized_nxt = 1'b1;
        desc.single   = 1'b1;
      end
      ACT_RESTART: begin
        finalized_nxt = 1'b0;
      end
      ACT_WRITE: begin
        priority if (!supported) begin
          desc.single = 1'b1;
          desc.status = ST_KIND;
        end else if (item.kind_code != KIND_VERSION && item.item_id == 32'd0) begin
          desc.single = 1'b1;
          desc.status = ST_ZERO_ID;
        end else if (finalized_r) begin
          desc.single = 1'b1;
          desc.status = ST_FINAL;
        end
      end
      default: begin
        desc.single = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finalized_r <= 1'b0;
    end else if (accept) begin
      finalized_r <= finalized_nxt;
    end
  end

endmodule

FILE: design/tlve_queue.sv
// Two-entry descriptor queue between the front and back of the TLV element encoder.
// Depends on tlve_pkg.
`timescale 1ns / 1ps
module tlve_queue import tlve_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  desc_t   push_desc,
  input  logic    pop,
  output logic    full,
  output q_head_t head
);

  desc_t      entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.desc  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && head.valid)) count_nxt = count_r + 2'd1;
    else if (!push && pop && head.valid) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop && head.valid) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: design/tlve_back.sv
// Back part of the TLV element encoder: serialises one descriptor into stream bytes
// and holds them in the output register. Depends on tlve_pkg.
`timescale 1ns / 1ps
module tlve_back import tlve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        active_r, active_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  last_idx_r, last_idx_nxt;
  logic [1:0]  idn_r, idn_nxt;
  logic [3:0]  plen_r, plen_nxt;
  logic [31:0] id_r, id_nxt;
  logic [63:0] pay_r, pay_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        adv;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    last_idx_nxt  = last_idx_r;
    idn_nxt       = idn_r;
    plen_nxt      = plen_r;
    id_nxt        = id_r;
    pay_nxt       = pay_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (active_r) begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.has_byte = 1'b1;
        out_data_nxt.status   = ST_OK;
        out_data_nxt.last     = (cnt_r == last_idx_r);
        if (cnt_r <= {2'd0, idn_r} + 4'd1) begin
          out_data_nxt.out_byte = id_r[31:24];
          id_nxt = id_r << 8;
        end else if (cnt_r == {2'd0, idn_r} + 4'd2) begin
          out_data_nxt.out_byte = {4'd0, plen_r};
        end else begin
          out_data_nxt.out_byte = pay_r[63:56];
          pay_nxt = pay_r << 8;
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == last_idx_r) active_nxt = 1'b0;
      end else if (head.valid) begin
        // The first result comes straight from the queue head, so items run back to back.
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        if (head.desc.single) begin
          out_data_nxt.out_byte = 8'd0;
          out_data_nxt.has_byte = 1'b0;
          out_data_nxt.last     = 1'b1;
          out_data_nxt.status   = head.desc.status;
        end else begin
          out_data_nxt.out_byte = head.desc.tag;
          out_data_nxt.has_byte = 1'b1;
          out_data_nxt.last     = 1'b0;
          out_data_nxt.status   = ST_OK;
          active_nxt   = 1'b1;
          cnt_nxt      = 4'd1;
          idn_nxt      = head.desc.idn;
          plen_nxt     = head.desc.plen;
          id_nxt       = head.desc.id_al;
          pay_nxt      = head.desc.pay_al;
          last_idx_nxt = {2'd0, head.desc.idn} + 4'd2 + head.desc.plen;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    last_idx_r <= last_idx_nxt;
    idn_r      <= idn_nxt;
    plen_r     <= plen_nxt;
    id_r       <= id_nxt;
    pay_r      <= pay_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/tlv_element_encoder_top.sv
// TLV element encoder, top level. The first result of a transaction passes through the
// queue and then the output register. An element gives 2 + id bytes + payload bytes
// output bytes (3 to 14), one at a time from the back-end serialiser, held while
// out_stall is set; rejected writes, finalize and unused actions give one result
// without a stream byte. A two-entry queue separates the front from the serialiser.
// Reset (synchronous, active low) empties the queue and output and reopens the stream.
`timescale 1ns / 1ps
module tlv_element_encoder_top import tlve_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic    accept;
  logic    q_full;
  logic    q_pop;
  desc_t   front_desc;
  q_head_t q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  tlve_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .desc   (front_desc)
  );

  tlve_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_desc (front_desc),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head)
  );

  tlve_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
